### sv/cgl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_pkg
// Shared types, constants and divider step for the color gradient lookup.
// ----------------------------------------------------------------------------
package cgl_pkg;

  localparam int MAX_STOPS = 7;
  localparam int NUM_REGS  = MAX_STOPS + 1;
  localparam int POS_W     = 16;
  localparam int CH_W      = 12;
  localparam int STOP_W    = POS_W + 3 * CH_W;
  localparam int KEY_W     = 18;
  localparam int CNT_W     = 3;
  localparam int IDX_W     = 3;
  localparam int R_W       = POS_W + 1;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS   = 4;
  localparam int PROD_W     = CH_W + 1 + R_W + 1;

  localparam logic [IDX_W-1:0] REG_STOP_COUNT = IDX_W'(0);
  localparam logic [CNT_W-1:0] STOP_COUNT_RST = CNT_W'(2);
  localparam logic [STOP_W-1:0] STOP_1_RST = 52'hFFFFFFFFF8000;
  localparam logic [POS_W-1:0] ONE_Q15 = 16'h8000;

  typedef logic [STOP_W-1:0] cgl_stop_t;
  typedef logic [2:0][CH_W-1:0] cgl_rgb_t;

  // segment chosen, before the ratio divide
  typedef struct packed {
    logic             found;
    logic             zspan;
    logic [POS_W-1:0] diff;
    logic [POS_W-1:0] span;
    cgl_rgb_t         lo;
    cgl_rgb_t         hi;
  } cgl_seg_t;

  // partial divide state
  typedef struct packed {
    logic             found;
    logic             zspan;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] rem;
    logic [R_W-1:0]   quo;
    cgl_rgb_t         lo;
    cgl_rgb_t         hi;
  } cgl_div_t;

  // ratio ready for blending
  typedef struct packed {
    logic           found;
    logic [R_W-1:0] ratio;
    cgl_rgb_t       lo;
    cgl_rgb_t       hi;
  } cgl_mix_t;

  // Four restoring-division steps: shift, compare, subtract.
  function automatic cgl_div_t div_steps(input cgl_div_t s);
    cgl_div_t         o;
    logic [POS_W:0]   t;
    o = s;
    for (int j = 0; j < DIV_BITS; j++) begin
      t = {o.rem, 1'b0};
      if (t >= {1'b0, o.span}) begin
        t = t - {1'b0, o.span};
        o.quo = {o.quo[R_W-2:0], 1'b1};
      end else begin
        o.quo = {o.quo[R_W-2:0], 1'b0};
      end
      o.rem = t[POS_W-1:0];
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### sv/cgl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_key_if / cgl_rgb_if
// Valid/ready channels for lookup keys and color results.
// ----------------------------------------------------------------------------
interface cgl_key_if;
  logic                valid;
  logic                ready;
  logic signed [17:0]  key;
  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface cgl_rgb_if;
  logic        valid;
  logic        ready;
  logic [11:0] red;
  logic [11:0] green;
  logic [11:0] blue;
  logic        found;
  modport source (output valid, output red, output green, output blue, output found,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input found,
                  output ready);
endinterface
`default_nettype wire

### sv/cgl_seg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_seg
// Clamp the key and register the first bracketing segment.
// ----------------------------------------------------------------------------
module cgl_seg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [cgl_pkg::KEY_W-1:0]   key_i,
  input  logic [cgl_pkg::CNT_W-1:0]          count_i,
  input  cgl_pkg::cgl_stop_t [cgl_pkg::MAX_STOPS-1:0] stops_i,
  output logic                               valid_o,
  output cgl_pkg::cgl_seg_t                  seg_o
);
  import cgl_pkg::*;

  logic [POS_W-1:0] key;
  logic [CNT_W-1:0] n;
  logic [MAX_STOPS-2:0] hit;
  cgl_seg_t seg_d, seg_q;
  logic valid_q;

  always_comb begin
    if (key_i[KEY_W-1]) begin
      key = '0;
    end else if (key_i[KEY_W-2:0] > {1'b0, ONE_Q15}) begin
      key = ONE_Q15;
    end else begin
      key = key_i[POS_W-1:0];
    end
    n = count_i;
    if (n < CNT_W'(2)) n = CNT_W'(2);
    if (n > CNT_W'(MAX_STOPS)) n = CNT_W'(MAX_STOPS);
  end

  always_comb begin
    for (int i = 0; i < MAX_STOPS - 1; i++) begin
      hit[i] = (CNT_W'(i + 1) < n) && (stops_i[i][POS_W-1:0] <= key) &&
               (key <= stops_i[i+1][POS_W-1:0]);
    end
  end

  // walk down so the lowest hit wins
  always_comb begin
    seg_d = '0;
    for (int i = MAX_STOPS - 2; i >= 0; i--) begin
      if (hit[i]) begin
        seg_d.found = 1'b1;
        seg_d.diff  = key - stops_i[i][POS_W-1:0];
        seg_d.span  = stops_i[i+1][POS_W-1:0] - stops_i[i][POS_W-1:0];
        seg_d.lo    = stops_i[i][STOP_W-1:POS_W];
        seg_d.hi    = stops_i[i+1][STOP_W-1:POS_W];
      end
    end
    seg_d.zspan = (seg_d.span == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
    end
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;

endmodule
`default_nettype wire

### sv/cgl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_div
// Pipelined restoring divider for the Q1.16 segment ratio.
// ----------------------------------------------------------------------------
module cgl_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cgl_pkg::cgl_seg_t seg_i,
  output logic              valid_o,
  output cgl_pkg::cgl_mix_t mix_o
);
  import cgl_pkg::*;

  cgl_div_t init;
  cgl_div_t stg_d [DIV_STAGES];
  cgl_div_t stg_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] valid_q;

  // top quotient bit: set only when the key sits on the upper stop
  always_comb begin
    init.found = seg_i.found;
    init.zspan = seg_i.zspan;
    init.span  = seg_i.span;
    init.lo    = seg_i.lo;
    init.hi    = seg_i.hi;
    if (seg_i.diff >= seg_i.span) begin
      init.rem = seg_i.diff - seg_i.span;
      init.quo = R_W'(1);
    end else begin
      init.rem = seg_i.diff;
      init.quo = '0;
    end
  end

  always_comb begin
    stg_d[0] = div_steps(init);
    for (int k = 1; k < DIV_STAGES; k++) begin
      stg_d[k] = div_steps(stg_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign valid_o     = valid_q[DIV_STAGES-1];
  assign mix_o.found = stg_q[DIV_STAGES-1].found;
  assign mix_o.ratio = stg_q[DIV_STAGES-1].zspan ? '0 : stg_q[DIV_STAGES-1].quo;
  assign mix_o.lo    = stg_q[DIV_STAGES-1].lo;
  assign mix_o.hi    = stg_q[DIV_STAGES-1].hi;

endmodule
`default_nettype wire

### sv/cgl_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_lerp
// Blend the two stop colors: lo + floor((hi - lo) * r / 65536).
// ----------------------------------------------------------------------------
module cgl_lerp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cgl_pkg::cgl_mix_t mix_i,
  output logic              valid_o,
  output logic              found_o,
  output cgl_pkg::cgl_rgb_t rgb_o
);
  import cgl_pkg::*;

  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [PROD_W-1:0] prod_q [3];
  cgl_rgb_t lo_q, rgb_d, rgb_q;
  logic found_q, found2_q;
  logic [1:0] valid_q;

  always_comb begin
    logic signed [CH_W:0]   dlt;
    logic signed [PROD_W-1:0] sh;
    logic [PROD_W-R_W:0]    sum;
    for (int c = 0; c < 3; c++) begin
      dlt = $signed({1'b0, mix_i.hi[c]}) - $signed({1'b0, mix_i.lo[c]});
      prod_d[c] = PROD_W'(dlt * $signed({1'b0, mix_i.ratio}));
    end
    for (int c = 0; c < 3; c++) begin
      sh  = prod_q[c] >>> (R_W - 1);
      sum = {{(PROD_W-R_W+1-CH_W){1'b0}}, lo_q[c]} + sh[PROD_W-R_W:0];
      rgb_d[c] = found_q ? sum[CH_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= prod_d[c];
      end
      lo_q     <= mix_i.lo;
      found_q  <= mix_i.found;
      rgb_q    <= rgb_d;
      found2_q <= found_q;
    end
  end

  assign valid_o = valid_q[1];
  assign found_o = found2_q;
  assign rgb_o   = rgb_q;

endmodule
`default_nettype wire

### sv/color_gradient_lookup.sv
`default_nettype none
// Throughput: one key word per cycle unless the output is held; one segment stage,
// four divider stages of four quotient bits each, one multiply stage and one add stage.
// A held output word stalls the whole pipeline in place.
// Reset clears all valid bits and loads the default gradient (black at 0.0, white at 1.0).
// ----------------------------------------------------------------------------
// color_gradient_lookup
// Piecewise linear color map over up to seven programmable color stops.
// ----------------------------------------------------------------------------
module color_gradient_lookup (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cgl_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [cgl_pkg::STOP_W-1:0]   cfg_data_i,
  cgl_key_if.sink                      key_in,
  cgl_rgb_if.source                    rgb_out
);
  import cgl_pkg::*;

  logic [CNT_W-1:0] count_q;
  cgl_stop_t [MAX_STOPS-1:0] stops_q;

  logic en;
  logic seg_valid, div_valid, out_valid;
  cgl_seg_t seg;
  cgl_mix_t mix;
  cgl_rgb_t rgb;
  logic found;

  // register file: count plus the stop words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= STOP_COUNT_RST;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stops_q[i] <= (i == 1) ? STOP_1_RST : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_STOP_COUNT) begin
        count_q <= cfg_data_i[CNT_W-1:0];
      end else begin
        stops_q[cfg_idx_i - IDX_W'(1)] <= cfg_data_i;
      end
    end
  end

  // advance every stage together unless the output word is held
  assign en           = !out_valid || rgb_out.ready;
  assign key_in.ready = en;

  cgl_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (key_in.valid),
    .key_i   (key_in.key),
    .count_i (count_q),
    .stops_i (stops_q),
    .valid_o (seg_valid),
    .seg_o   (seg)
  );

  cgl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (seg_valid),
    .seg_i   (seg),
    .valid_o (div_valid),
    .mix_o   (mix)
  );

  cgl_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .mix_i   (mix),
    .valid_o (out_valid),
    .found_o (found),
    .rgb_o   (rgb)
  );

  assign rgb_out.valid = out_valid;
  assign rgb_out.red   = rgb[0];
  assign rgb_out.green = rgb[1];
  assign rgb_out.blue  = rgb[2];
  assign rgb_out.found = found;

endmodule
`default_nettype wire

### sv/cgl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_checker
// Port-level checks for the color gradient lookup.
// ----------------------------------------------------------------------------
module cgl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [11:0] red_i,
  input logic [11:0] green_i,
  input logic [11:0] blue_i,
  input logic        found_i
);

  // a held word keeps its color
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_i) &&
    $stable(green_i) && $stable(blue_i) && $stable(found_i))
    else $error("output word changed while stalled");

  // a miss is black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> red_i == '0 && green_i == '0 && blue_i == '0)
    else $error("miss returned a color");

  // input is taken exactly when the output side can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output stall");

endmodule

bind color_gradient_lookup cgl_checker u_cgl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (key_in.ready),
  .out_valid_i (rgb_out.valid),
  .out_ready_i (rgb_out.ready),
  .red_i       (rgb_out.red),
  .green_i     (rgb_out.green),
  .blue_i      (rgb_out.blue),
  .found_i     (rgb_out.found)
);
`default_nettype wire

### verif/color_gradient_lookup_tb.sv
// ----------------------------------------------------------------------------
// color_gradient_lookup_tb
// Drives lookup keys through the color map under several stop tables and
// checks every color word against a predicted color, with random gaps on both
// sides of the pipeline.
// ----------------------------------------------------------------------------
module color_gradient_lookup_tb;
  import cgl_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            found;
  } color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [STOP_W-1:0] cfg_data_i = '0;

  cgl_key_if key_in ();
  cgl_rgb_if rgb_out ();

  color_gradient_lookup u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_in     (key_in.sink),
    .rgb_out    (rgb_out.source)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the stop table, updated with every register write.
  logic [CNT_W-1:0]  stop_count_q;
  logic [STOP_W-1:0] stop_tbl [MAX_STOPS];

  color_t expected_colors [$];
  int     mismatches;
  int     cycle_cnt;

  // Start idle: no key word offered, result side ready.
  initial begin
    key_in.valid  = 1'b0;
    key_in.key    = '0;
    rgb_out.ready = 1'b1;
  end

  // Short gaps mostly, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Predict the color word for one key using the shadow stop table.
  function automatic color_t lookup_color(logic [KEY_W-1:0] raw);
    color_t c;
    logic [16:0] k;
    int n, seg;
    logic [15:0] plo, phi;
    logic [63:0] r, a, b;
    c = '0;
    seg = -1;
    if (raw[KEY_W-1]) k = '0;
    else if (raw > 18'd32768) k = 17'd32768;
    else k = raw[16:0];
    n = stop_count_q;
    if (n < 2) n = 2;
    if (n > MAX_STOPS) n = MAX_STOPS;
    for (int i = 0; i + 1 < n; i++) begin
      if (seg < 0 && stop_tbl[i][15:0] <= k && k <= stop_tbl[i+1][15:0]) seg = i;
    end
    if (seg < 0) return c;
    plo = stop_tbl[seg][15:0];
    phi = stop_tbl[seg+1][15:0];
    r = 0;
    if (phi != plo) r = (64'(k - plo) << 16) / 64'(phi - plo);
    if (r > 65536) r = 65536;
    for (int ch = 0; ch < 3; ch++) begin
      a = 64'(stop_tbl[seg][16 + 12*ch +: 12]);
      b = 64'(stop_tbl[seg+1][16 + 12*ch +: 12]);
      a = (a * (65536 - r) + b * r) >> 16;
      case (ch)
        0: c.red   = a[11:0];
        1: c.green = a[11:0];
        default: c.blue = a[11:0];
      endcase
    end
    c.found = 1'b1;
    return c;
  endfunction

  // Write one register, then drop the write enable and update the shadow table; the block must be idle.
  task automatic write_reg(int idx, logic [STOP_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= IDX_W'(idx);
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_STOP_COUNT) stop_count_q = data[CNT_W-1:0];
    else stop_tbl[idx-1] = data;
  endtask

  function automatic logic [STOP_W-1:0] make_stop(int pos);
    return {12'($urandom), 12'($urandom), 12'($urandom), 16'(pos)};
  endfunction

  // Send one key word, hold it until accepted, then drop valid unless
  // another word follows right away.
  task automatic send_key(logic [KEY_W-1:0] k);
    int g;
    key_in.valid <= 1'b1;
    key_in.key   <= k;
    do @(posedge clk_i); while (!key_in.ready);
    expected_colors.push_back(lookup_color(k));
    g = gap_len();
    if (g > 0) begin
      key_in.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Wait for all color words, then let the pipeline settle.
  task automatic drain();
    key_in.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random key biased toward the 0..1 range with out-of-range noise.
  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0: return KEY_W'($urandom);
      1: return KEY_W'($urandom_range(32760, 32776));
      2: return KEY_W'($urandom_range(0, 8));
      default: return KEY_W'($urandom_range(0, 32768));
    endcase
  endfunction

  // Ascending positions in 0..1, first at 0 and last at 1 most of the time.
  task automatic load_ascending(int n);
    int p;
    write_reg(REG_STOP_COUNT, STOP_W'(n));
    p = 0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (i == 0) p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : 0;
      else if (i == n - 1 && $urandom_range(0, 3) != 0) p = 32768;
      else p = p + $urandom_range(1, 32768 / n);
      write_reg(i + 1, make_stop(p));
    end
  endtask

  // Default gradient after reset, then extremes of the key.
  task automatic test_reset_gradient();
    logic [KEY_W-1:0] keys [10] = '{18'h20000, 18'h3FFFF, 18'd0, 18'd1, 18'd16384,
                                    18'd32767, 18'd32768, 18'd32769, 18'h1FFFF, 18'h15555};
    foreach (keys[i]) send_key(keys[i]);
    drain();
  endtask

  // Odd tables: unordered and equal positions, counts 0, 1 and 7,
  // positions above one, no bracketing segment.
  task automatic test_odd_tables();
    write_reg(REG_STOP_COUNT, STOP_W'(0));
    write_reg(1, {36'hFFFFFFFFF, 16'd100});
    write_reg(2, {36'h000000000, 16'd100});
    send_key(18'd100);
    send_key(18'd50);
    send_key(18'd200);
    drain();
    write_reg(REG_STOP_COUNT, STOP_W'(1));
    write_reg(1, make_stop(30000));
    write_reg(2, make_stop(65535));
    send_key(18'd32768);
    send_key(18'd0);
    drain();
    write_reg(REG_STOP_COUNT, STOP_W'(7));
    write_reg(3, make_stop(1000));
    write_reg(4, make_stop(40000));
    write_reg(5, make_stop(0));
    write_reg(6, make_stop(32768));
    write_reg(7, {36'hFFFFFFFFF, 16'hFFFF});
    send_key(18'd500);
    send_key(18'd20000);
    send_key(18'd32768);
    send_key(18'h3FFFF);
    drain();
  endtask

  // Random stop tables under random keys.
  task automatic test_random_tables();
    for (int t = 0; t < 40; t++) begin
      if (t % 8 == 7) begin
        write_reg(REG_STOP_COUNT, STOP_W'($urandom));
        for (int i = 1; i <= MAX_STOPS; i++) write_reg(i, STOP_W'({$urandom, $urandom}));
      end else begin
        load_ascending((t % 6) + 2);
      end
      for (int j = 0; j < 45; j++) send_key(rand_key());
      drain();
    end
  endtask

  // Check each accepted color word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rgb_out.valid && rgb_out.ready) begin
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color word %h",
          {rgb_out.red, rgb_out.green, rgb_out.blue, rgb_out.found});
      end else begin
        color_t e;
        e = expected_colors.pop_front();
        if (e.red !== rgb_out.red || e.green !== rgb_out.green ||
            e.blue !== rgb_out.blue || e.found !== rgb_out.found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: expected r%h g%h b%h f%b, got r%h g%h b%h f%b",
              e.red, e.green, e.blue, e.found,
              rgb_out.red, rgb_out.green, rgb_out.blue, rgb_out.found);
        end
      end
    end
  end

  // Random stalls on the result side, with stall-free stretches.
  initial begin
    int g;
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        rgb_out.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
        rgb_out.ready <= 1'b1;
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycle_cnt = 0;
    stop_count_q = STOP_COUNT_RST;
    foreach (stop_tbl[i]) stop_tbl[i] = '0;
    stop_tbl[1] = STOP_1_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_gradient();
    test_odd_tables();
    test_random_tables();
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
sv/cgl_pkg.sv
sv/cgl_if.sv
sv/cgl_seg.sv
sv/cgl_div.sv
sv/cgl_lerp.sv
sv/color_gradient_lookup.sv
sv/cgl_checker.sv
verif/color_gradient_lookup_tb.sv
